// ===== rtl/core/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared widths and defaults for the LRU page cache.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int LPC_TAG_W       = 10;
    localparam int LPC_DATA_W      = 32;
    localparam int LPC_ENTRIES_DEF = 8;

endpackage

// ===== rtl/core/lru_page_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru_page_cache_unit
// Fully associative page cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries page_number and fill_data.
//   Output channel (out_valid/out_ready) returns hit and data_out: the cached
//   data on a hit, fill_data on a miss. One result per input transaction.
//   out_valid rises once the input has passed the input register and then a
//   single-pass tag match and recency update into the result register.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the parallel tag match over all ENTRIES slots and the age update are combinational.
//   Each slot keeps an age; age 0 is most recent, age ENTRIES-1 is evicted
//   once all slots are filled. Slots fill in index order.
//   Reset empties the cache (fill count and ages cleared) and drops any
//   transaction in flight.
//   When the receiver stalls, the result register holds, the input register
//   holds behind it and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lru_page_cache_unit
    import lpc_pkg::*;
#(
    parameter int ENTRIES = LPC_ENTRIES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [LPC_TAG_W-1:0]         page_number,
    input  logic signed [LPC_DATA_W-1:0] fill_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic signed [LPC_DATA_W-1:0] data_out
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic                         in_valid_reg;
    logic [LPC_TAG_W-1:0]         in_tag_reg;
    logic signed [LPC_DATA_W-1:0] in_data_reg;

    logic                         out_valid_reg;
    logic                         hit_reg, hit_next;
    logic signed [LPC_DATA_W-1:0] data_reg, data_next;

    logic [LPC_TAG_W-1:0]         tag_reg   [ENTRIES];
    logic signed [LPC_DATA_W-1:0] value_reg [ENTRIES];
    logic [AW-1:0]                age_reg   [ENTRIES];
    logic [AW-1:0]                age_next  [ENTRIES];
    logic [CW-1:0]                count_reg, count_next;

    logic                 advance;
    logic                 proc;
    logic                 full;
    logic [ENTRIES-1:0]   slot_valid;
    logic [ENTRIES-1:0]   match;
    logic [ENTRIES-1:0]   victim;
    logic [ENTRIES-1:0]   wr_sel;
    logic                 any_match;
    logic [AW-1:0]        hit_age;
    logic [LPC_DATA_W-1:0] hit_value;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign proc      = in_valid_reg && advance;
    assign full      = (count_reg == CW'(ENTRIES));
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign data_out  = data_reg;

    always_comb
    begin
        hit_value = '0;
        hit_age   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_valid[i] = (CW'(i) < count_reg);
            match[i]      = slot_valid[i] && (tag_reg[i] == in_tag_reg);
            victim[i]     = (age_reg[i] == AW'(ENTRIES - 1));
            if (match[i])
            begin
                hit_value = hit_value | value_reg[i];
                hit_age   = hit_age | age_reg[i];
            end
        end
        any_match = |match;
    end

    always_comb
    begin
        count_next = count_reg;
        hit_next   = any_match;
        data_next  = any_match ? signed'(hit_value) : in_data_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            wr_sel[i]   = 1'b0;
            age_next[i] = age_reg[i];
        end
        if (proc)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (any_match)
                begin
                    if (match[i])
                        age_next[i] = '0;
                    else if (slot_valid[i] && (age_reg[i] < hit_age))
                        age_next[i] = age_reg[i] + AW'(1);
                end
                else
                begin
                    wr_sel[i] = full ? victim[i] : (CW'(i) == count_reg);
                    if (wr_sel[i])
                        age_next[i] = '0;
                    else if (slot_valid[i])
                        age_next[i] = age_reg[i] + AW'(1);
                end
            end
            if (!any_match && !full)
                count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < ENTRIES; i++)
                age_reg[i] <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
                age_reg[i] <= age_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_tag_reg  <= page_number;
            in_data_reg <= fill_data;
        end
        if (proc)
        begin
            hit_reg  <= hit_next;
            data_reg <= data_next;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (wr_sel[i])
            begin
                tag_reg[i]   <= in_tag_reg;
                value_reg[i] <= in_data_reg;
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("fill count beyond capacity");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("page present in more than one slot");

    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> $onehot(victim))
        else $error("no unique least recent slot while full");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && !any_match && !full) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("miss while not full did not allocate a slot");

    a_hit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> (out_valid_reg && (hit_reg == $past(any_match))))
        else $error("result does not reflect tag match");

endmodule
